// ----- design/nrta_pkg.sv -----
package nrta_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH       = 3'd0,
    REQ_POP        = 3'd1,
    REQ_START      = 3'd2,
    REQ_STOP       = 3'd3,
    REQ_COND_START = 3'd4,
    REQ_COND_STOP  = 3'd5,
    REQ_READ_REG   = 3'd6,
    REQ_READ_PAIR  = 3'd7
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_POP_EMPTY  = 3'd1,
    ST_POP_MISM   = 3'd2,
    ST_ALREADY    = 3'd3,
    ST_NOT_SOLO   = 3'd4,
    ST_STACK_FULL = 3'd5,
    ST_PUSH_SOLO  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    FSM_CLEAR = 2'd0,
    FSM_IDLE  = 2'd1,
    FSM_EXEC  = 2'd2
  } fsm_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  region_id;
    logic [5:0]  child_region;
    logic        was_running_in;
    logic [63:0] now_wall;
    logic [63:0] now_mem;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        already_running;
    logic [63:0] acc_wall;
    logic [63:0] acc_mem;
    logic        region_used;
    logic [5:0]  stack_level;
    logic [5:0]  top_region;
  } out_rsp_t;

endpackage

// ----- design/nested_region_time_attribution_top.sv -----
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready   | nrta_pkg::in_req_t
// out     | out | out_valid / out_ready | nrta_pkg::out_rsp_t
// cfg     | in  | cfg_valid / cfg_ready | detail_enable (1 bit)
// each request passes through a memory read, then modify and write back.
// after reset a clearing pass sweeps all 2**(2*RW) pair memory entries (4096 by
// default); the region memories are swept while it covers the first 2**RW of them.
// no request is taken during the pass; cfg writes are always taken.
// the output register frees the input side; a stalled result holds the next request.
module nested_region_time_attribution_top #(
  parameter int NUM_REGIONS = 64,
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  nrta_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nrta_pkg::out_rsp_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int RW  = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int PW  = 2 * RW;
  localparam int SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int NRD = 1 << RW;
  localparam int NPD = 1 << PW;

  // memories
  logic [63:0] reg_wall_mem [NRD];
  logic [63:0] reg_mem_mem  [NRD];
  logic [63:0] solo_wall_mem[NRD];
  logic [63:0] solo_mem_mem [NRD];
  logic [63:0] pair_wall_mem[NPD];
  logic [63:0] pair_mem_mem [NPD];
  logic [RW-1:0] stack_mem  [STACK_DEPTH];

  logic [NRD-1:0] solo_run_r, used_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [RW-1:0] top_r, top_nxt;   // cached top of stack
  logic [RW-1:0] par_r, par_nxt;   // cached entry below the top
  logic [63:0] sw_wall_r, sw_mem_r;
  logic detail_r;
  nrta_pkg::fsm_t state_r, state_nxt;
  logic [PW-1:0] clr_r;
  nrta_pkg::in_req_t req_r;
  logic out_valid_r;
  nrta_pkg::out_rsp_t out_r;

  // read data
  logic [63:0] rd_rw, rd_rm, rd_sw, rd_sm, rd_pw, rd_pm;
  logic [RW-1:0] rd_stk;

  logic [5:0] id_in, ch_in;
  logic [RW-1:0] id_a, ch_a, id_e;
  logic [PW-1:0] pair_a_in;
  logic [CW-1:0] stk_ra;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == nrta_pkg::FSM_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign id_in     = in_data.region_id;
  assign ch_in     = in_data.child_region;
  assign id_a      = RW'(id_in);
  assign ch_a      = RW'(ch_in);
  assign id_e      = RW'(req_r.region_id);

  // pair address for read: pair read uses (id,child); pop uses (parent,id)
  assign pair_a_in = (in_data.req_type == nrta_pkg::REQ_READ_PAIR) ? {id_a, ch_a}
                                                                   : {par_r, id_a};

  // third entry from the top becomes the new parent after a pop
  assign stk_ra = count_r - CW'(3);
  always_ff @(posedge clk) begin
    if (accept) rd_stk <= stack_mem[stk_ra[SW-1:0]];
  end

  // read port for region/solo/pair memories
  logic [RW-1:0] reg_ra;
  assign reg_ra = (in_data.req_type == nrta_pkg::REQ_PUSH) ? top_r : id_a;
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_rw <= reg_wall_mem[reg_ra];
      rd_rm <= reg_mem_mem[reg_ra];
      rd_sw <= solo_wall_mem[id_a];
      rd_sm <= solo_mem_mem[id_a];
      rd_pw <= pair_wall_mem[pair_a_in];
      rd_pm <= pair_mem_mem[pair_a_in];
    end
  end

  // execute stage decisions
  nrta_pkg::req_type_t rt;
  logic valid_id, valid_ch;
  logic solo, empty, full;
  assign rt       = nrta_pkg::req_type_t'(req_r.req_type);
  assign valid_id = {26'd0, req_r.region_id} < 32'(NUM_REGIONS);
  assign valid_ch = {26'd0, req_r.child_region} < 32'(NUM_REGIONS);
  assign solo     = solo_run_r[id_e];
  assign empty    = (count_r == '0);
  assign full     = ({{(32-CW){1'b0}}, count_r} >= 32'(STACK_DEPTH));

  logic [63:0] dw_sw, dm_sw, dw_so, dm_so;
  assign dw_sw = req_r.now_wall - sw_wall_r;
  assign dm_sw = req_r.now_mem - sw_mem_r;
  assign dw_so = req_r.now_wall - rd_sw;
  assign dm_so = req_r.now_mem - rd_sm;

  logic wr_reg, wr_solo, wr_pair, wr_stack, set_used, set_solo, clr_solo, upd_sw;
  logic [RW-1:0] reg_wa;
  logic [63:0] reg_ww, reg_wm;
  nrta_pkg::out_rsp_t rsp;

  // fsm next state and execute
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    top_nxt   = top_r;
    par_nxt   = par_r;
    wr_reg = 1'b0; wr_solo = 1'b0; wr_pair = 1'b0; wr_stack = 1'b0;
    set_used = 1'b0; set_solo = 1'b0; clr_solo = 1'b0; upd_sw = 1'b0;
    reg_wa = id_e;
    reg_ww = rd_rw + dw_sw;
    reg_wm = rd_rm + dm_sw;
    rsp = '0;
    case (state_r)
      nrta_pkg::FSM_CLEAR: begin
        if (clr_r == '1) state_nxt = nrta_pkg::FSM_IDLE;
      end
      nrta_pkg::FSM_IDLE: begin
        if (accept) state_nxt = nrta_pkg::FSM_EXEC;
      end
      nrta_pkg::FSM_EXEC: begin
        state_nxt = nrta_pkg::FSM_IDLE;
        if (valid_id) begin
          case (rt)
            nrta_pkg::REQ_PUSH: begin
              if (solo) rsp.status = nrta_pkg::ST_PUSH_SOLO;
              else if (full) rsp.status = nrta_pkg::ST_STACK_FULL;
              else begin
                set_used = 1'b1;
                wr_reg   = !empty;
                reg_wa   = top_r;
                upd_sw   = 1'b1;
                wr_stack = 1'b1;
                count_nxt = count_r + CW'(1);
                top_nxt  = id_e;
                par_nxt  = top_r;
              end
            end
            nrta_pkg::REQ_POP: begin
              if (empty) rsp.status = nrta_pkg::ST_POP_EMPTY;
              else if (top_r != id_e) rsp.status = nrta_pkg::ST_POP_MISM;
              else begin
                wr_reg = 1'b1;
                wr_pair = (count_r > CW'(1)) && detail_r;
                upd_sw = 1'b1;
                count_nxt = count_r - CW'(1);
                top_nxt = (count_r > CW'(1)) ? par_r : '0;
                par_nxt = (count_r > CW'(2)) ? rd_stk : '0;
              end
            end
            nrta_pkg::REQ_START, nrta_pkg::REQ_COND_START: begin
              if (solo) begin
                if (rt == nrta_pkg::REQ_START) rsp.status = nrta_pkg::ST_ALREADY;
                else begin
                  set_used = 1'b1;
                  rsp.already_running = 1'b1;
                end
              end else begin
                set_used = 1'b1;
                set_solo = 1'b1;
                wr_solo  = 1'b1;
              end
            end
            nrta_pkg::REQ_STOP, nrta_pkg::REQ_COND_STOP: begin
              if (!(rt == nrta_pkg::REQ_COND_STOP && req_r.was_running_in)) begin
                if (!solo) rsp.status = nrta_pkg::ST_NOT_SOLO;
                else begin
                  clr_solo = 1'b1;
                  wr_reg = 1'b1;
                  reg_ww = rd_rw + dw_so;
                  reg_wm = rd_rm + dm_so;
                end
              end
            end
            nrta_pkg::REQ_READ_REG: begin
              rsp.acc_wall = rd_rw;
              rsp.acc_mem  = rd_rm;
              rsp.region_used = used_r[id_e];
            end
            nrta_pkg::REQ_READ_PAIR: begin
              if (valid_ch) begin
                rsp.acc_wall = rd_pw;
                rsp.acc_mem  = rd_pm;
              end
            end
            default: ;
          endcase
        end
        rsp.stack_level = 6'(count_nxt);
        rsp.top_region  = 6'(top_nxt);
      end
      default: state_nxt = nrta_pkg::FSM_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nrta_pkg::FSM_CLEAR;
      clr_r <= '0;
      count_r <= '0;
      top_r <= '0;
      par_r <= '0;
      sw_wall_r <= '0;
      sw_mem_r <= '0;
      detail_r <= 1'b0;
      solo_run_r <= '0;
      used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      top_r <= top_nxt;
      par_r <= par_nxt;
      if (state_r == nrta_pkg::FSM_CLEAR) clr_r <= clr_r + PW'(1);
      if (cfg_valid) detail_r <= cfg_data;
      if (upd_sw) begin
        sw_wall_r <= req_r.now_wall;
        sw_mem_r  <= req_r.now_mem;
      end
      if (set_used) used_r[id_e] <= 1'b1;
      if (set_solo) solo_run_r[id_e] <= 1'b1;
      if (clr_solo) solo_run_r[id_e] <= 1'b0;
      if (state_r == nrta_pkg::FSM_EXEC) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) req_r <= in_data;
    if (state_r == nrta_pkg::FSM_EXEC) out_r <= rsp;
  end

  // memory writes, with the clearing pass
  logic [PW-1:0] pair_wa;
  assign pair_wa = {par_r, id_e};
  always_ff @(posedge clk) begin
    if (state_r == nrta_pkg::FSM_CLEAR) begin
      pair_wall_mem[clr_r] <= '0;
      pair_mem_mem[clr_r]  <= '0;
      if (clr_r[PW-1:RW] == '0) begin
        reg_wall_mem[clr_r[RW-1:0]]  <= '0;
        reg_mem_mem[clr_r[RW-1:0]]   <= '0;
        solo_wall_mem[clr_r[RW-1:0]] <= '0;
        solo_mem_mem[clr_r[RW-1:0]]  <= '0;
      end
    end else begin
      if (wr_reg) begin
        reg_wall_mem[reg_wa] <= reg_ww;
        reg_mem_mem[reg_wa]  <= reg_wm;
      end
      if (wr_solo) begin
        solo_wall_mem[id_e] <= req_r.now_wall;
        solo_mem_mem[id_e]  <= req_r.now_mem;
      end
      if (wr_pair) begin
        pair_wall_mem[pair_wa] <= rd_pw + dw_sw;
        pair_mem_mem[pair_wa]  <= rd_pm + dm_sw;
      end
    end
    if (wr_stack) stack_mem[count_r[SW-1:0]] <= id_e;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- verif/nrta_checker.sv -----
`timescale 1ns / 1ps

module nrta_checker #(
  parameter int NUM_REGIONS = 64,
  parameter int STACK_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  nrta_pkg::in_req_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  nrta_pkg::out_rsp_t  out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_data,
  output int                  fail_count,
  output int                  pending_count
);

  // shadow of the profiling state
  logic [63:0] wall_acc [NUM_REGIONS];
  logic [63:0] mem_acc [NUM_REGIONS];
  logic [63:0] solo_wall [NUM_REGIONS];
  logic [63:0] solo_mem [NUM_REGIONS];
  logic        solo_on [NUM_REGIONS];
  logic        ever_used [NUM_REGIONS];
  logic [63:0] pair_wall [NUM_REGIONS*NUM_REGIONS];
  logic [63:0] pair_mem [NUM_REGIONS*NUM_REGIONS];
  logic [5:0]  region_stack [STACK_DEPTH];
  int          depth;
  logic [63:0] mark_wall;
  logic [63:0] mark_mem;
  logic        detail_on;

  nrta_pkg::out_rsp_t expected_rsps [$];

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (fail_count < 40)
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic void clear_state();
    for (int i = 0; i < NUM_REGIONS; i++) begin
      wall_acc[i] = '0;
      mem_acc[i] = '0;
      solo_wall[i] = '0;
      solo_mem[i] = '0;
      solo_on[i] = 1'b0;
      ever_used[i] = 1'b0;
    end
    for (int i = 0; i < NUM_REGIONS*NUM_REGIONS; i++) begin
      pair_wall[i] = '0;
      pair_mem[i] = '0;
    end
    for (int i = 0; i < STACK_DEPTH; i++) region_stack[i] = '0;
    depth = 0;
    mark_wall = '0;
    mark_mem = '0;
    detail_on = 1'b0;
  endfunction

  // charge one request against the shadow state and build its response
  function automatic nrta_pkg::out_rsp_t attribute_event(nrta_pkg::in_req_t r);
    nrta_pkg::out_rsp_t   rsp;
    int                   id;
    int                   top;
    int                   k;
    nrta_pkg::req_type_t  kind;
    rsp = '0;
    id = r.region_id;
    kind = nrta_pkg::req_type_t'(r.req_type);
    rsp.status = nrta_pkg::ST_OK;
    if (id < NUM_REGIONS) begin
      case (kind)
        nrta_pkg::REQ_PUSH: begin
          if (solo_on[id]) begin
            rsp.status = nrta_pkg::ST_PUSH_SOLO;
          end else if (depth >= STACK_DEPTH) begin
            rsp.status = nrta_pkg::ST_STACK_FULL;
          end else begin
            ever_used[id] = 1'b1;
            if (depth > 0) begin
              top = region_stack[depth-1];
              wall_acc[top] += r.now_wall - mark_wall;
              mem_acc[top] += r.now_mem - mark_mem;
            end
            mark_wall = r.now_wall;
            mark_mem = r.now_mem;
            region_stack[depth] = r.region_id;
            depth++;
          end
        end
        nrta_pkg::REQ_POP: begin
          if (depth == 0) begin
            rsp.status = nrta_pkg::ST_POP_EMPTY;
          end else if (region_stack[depth-1] != r.region_id) begin
            rsp.status = nrta_pkg::ST_POP_MISM;
          end else begin
            wall_acc[id] += r.now_wall - mark_wall;
            mem_acc[id] += r.now_mem - mark_mem;
            depth--;
            if (depth > 0 && detail_on) begin
              k = region_stack[depth-1] * NUM_REGIONS + id;
              pair_wall[k] += r.now_wall - mark_wall;
              pair_mem[k] += r.now_mem - mark_mem;
            end
            mark_wall = r.now_wall;
            mark_mem = r.now_mem;
          end
        end
        nrta_pkg::REQ_START, nrta_pkg::REQ_COND_START: begin
          if (solo_on[id]) begin
            if (kind == nrta_pkg::REQ_START) begin
              rsp.status = nrta_pkg::ST_ALREADY;
            end else begin
              ever_used[id] = 1'b1;
              rsp.already_running = 1'b1;
            end
          end else begin
            ever_used[id] = 1'b1;
            solo_on[id] = 1'b1;
            solo_wall[id] = r.now_wall;
            solo_mem[id] = r.now_mem;
          end
        end
        nrta_pkg::REQ_STOP, nrta_pkg::REQ_COND_STOP: begin
          if (!(kind == nrta_pkg::REQ_COND_STOP && r.was_running_in)) begin
            if (!solo_on[id]) begin
              rsp.status = nrta_pkg::ST_NOT_SOLO;
            end else begin
              solo_on[id] = 1'b0;
              wall_acc[id] += r.now_wall - solo_wall[id];
              mem_acc[id] += r.now_mem - solo_mem[id];
            end
          end
        end
        nrta_pkg::REQ_READ_REG: begin
          rsp.acc_wall = wall_acc[id];
          rsp.acc_mem = mem_acc[id];
          rsp.region_used = ever_used[id];
        end
        default: begin
          if (r.child_region < NUM_REGIONS) begin
            k = id * NUM_REGIONS + r.child_region;
            rsp.acc_wall = pair_wall[k];
            rsp.acc_mem = pair_mem[k];
          end
        end
      endcase
    end
    rsp.stack_level = depth[5:0];
    rsp.top_region = depth > 0 ? region_stack[depth-1] : 6'd0;
    return rsp;
  endfunction

  initial begin
    fail_count = 0;
    pending_count = 0;
    clear_state();
  end

  // watch all three channels on the same edge the block does
  always @(posedge clk) begin
    nrta_pkg::out_rsp_t want;
    if (!rst_n) begin
      clear_state();
      expected_rsps.delete();
    end else begin
      if (cfg_valid && cfg_ready) detail_on = cfg_data;
      if (in_valid && in_ready) expected_rsps.push_back(attribute_event(in_data));
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", out_data.acc_wall, '0);
        end else begin
          want = expected_rsps.pop_front();
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.already_running != want.already_running)
            report_mismatch("already_running", out_data.already_running,
                            want.already_running);
          if (out_data.acc_wall != want.acc_wall)
            report_mismatch("acc_wall", out_data.acc_wall, want.acc_wall);
          if (out_data.acc_mem != want.acc_mem)
            report_mismatch("acc_mem", out_data.acc_mem, want.acc_mem);
          if (out_data.region_used != want.region_used)
            report_mismatch("region_used", out_data.region_used, want.region_used);
          if (out_data.stack_level != want.stack_level)
            report_mismatch("stack_level", out_data.stack_level, want.stack_level);
          if (out_data.top_region != want.top_region)
            report_mismatch("top_region", out_data.top_region, want.top_region);
        end
      end
    end
    pending_count = expected_rsps.size();
  end

endmodule

// ----- verif/nested_region_time_attribution_top_tb.sv -----
`timescale 1ns / 1ps

module nested_region_time_attribution_top_tb;

  localparam int NUM_REGIONS = 64;
  localparam int STACK_DEPTH = 32;
  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  nrta_pkg::in_req_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  nrta_pkg::out_rsp_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;
  int                 fail_count;
  int                 pending_count;
  int                 cycles = 0;

  // stimulus-side view of the stack, only to steer request choice
  int          open_regions [$];
  bit          solo_open [NUM_REGIONS];
  logic [63:0] clock_wall = '0;
  logic [63:0] clock_mem = '0;
  bit          eager_sender = 1'b0;

  nested_region_time_attribution_top #(
    .NUM_REGIONS(NUM_REGIONS),
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  nrta_checker #(
    .NUM_REGIONS(NUM_REGIONS),
    .STACK_DEPTH(STACK_DEPTH)
  ) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // response side: random stalls, one long hold once traffic is flowing
  int  rsp_seen = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;
  bit  eager_receiver = 1'b0;
  always @(posedge clk) begin
    int pick;
    pick = $urandom_range(0, 999);
    if (out_valid && out_ready) rsp_seen++;
    if (pick < 5) eager_receiver = ~eager_receiver;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!long_hold_done && rsp_seen >= 300) begin
      long_hold_done = 1'b1;
      hold_left = 400;
      out_ready <= 1'b0;
    end else if (eager_receiver || pick < 650) begin
      out_ready <= 1'b1;
    end else if (pick < 950) begin
      out_ready <= 1'b0;
      hold_left = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b0;
      hold_left = $urandom_range(10, 60);
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (eager_sender || pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_request(nrta_pkg::in_req_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and let every outstanding response drain
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_detail(logic value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic nrta_pkg::in_req_t make_request(nrta_pkg::req_type_t kind, int id,
                                                     int child, bit was_running);
    nrta_pkg::in_req_t r;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_wall = {$urandom, $urandom};
    else clock_wall += $urandom_range(0, 2000);
    if (pick >= 3 && pick < 6) clock_mem = {$urandom, $urandom};
    else if (pick < 50) clock_mem += $urandom_range(0, 4096);
    else clock_mem -= $urandom_range(0, 1024);
    r.req_type = kind;
    r.region_id = id[5:0];
    r.child_region = child[5:0];
    r.was_running_in = was_running;
    r.now_wall = clock_wall;
    r.now_mem = clock_mem;
    return r;
  endfunction

  function automatic int pick_region();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, NUM_REGIONS - 1);
    return $urandom_range(0, 7);
  endfunction

  // mostly well-formed nesting and start/stop pairs, with some noise
  task automatic send_random(int count, int push_weight);
    int                pick;
    int                id;
    int                child;
    nrta_pkg::in_req_t r;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      id = pick_region();
      child = $urandom_range(0, NUM_REGIONS - 1);
      if ($urandom_range(0, 199) == 0) eager_sender = ~eager_sender;
      if (pick < push_weight) begin
        r = make_request(nrta_pkg::REQ_PUSH, id, child, $urandom_range(0, 1));
        if (!solo_open[id] && open_regions.size() < STACK_DEPTH)
          open_regions.push_back(id);
      end else if (pick < push_weight + 25) begin
        if (open_regions.size() > 0 && $urandom_range(0, 99) < 85)
          id = open_regions[$];
        r = make_request(nrta_pkg::REQ_POP, id, child, $urandom_range(0, 1));
        if (open_regions.size() > 0 && open_regions[$] == id)
          void'(open_regions.pop_back());
      end else if (pick < push_weight + 35) begin
        r = make_request(nrta_pkg::REQ_START, id, child, $urandom_range(0, 1));
        solo_open[id] = 1'b1;
      end else if (pick < push_weight + 45) begin
        r = make_request(nrta_pkg::REQ_STOP, id, child, $urandom_range(0, 1));
        solo_open[id] = 1'b0;
      end else if (pick < push_weight + 50) begin
        r = make_request(nrta_pkg::REQ_COND_START, id, child, $urandom_range(0, 1));
        solo_open[id] = 1'b1;
      end else if (pick < push_weight + 55) begin
        r = make_request(nrta_pkg::REQ_COND_STOP, id, child, $urandom_range(0, 1));
        if (!r.was_running_in) solo_open[id] = 1'b0;
      end else if (pick < push_weight + 63) begin
        r = make_request(nrta_pkg::REQ_READ_REG, id, child, $urandom_range(0, 1));
      end else begin
        if (open_regions.size() > 0 && $urandom_range(0, 1) == 1)
          id = open_regions[$];
        if ($urandom_range(0, 1) == 1) child = pick_region();
        r = make_request(nrta_pkg::REQ_READ_PAIR, id, child, $urandom_range(0, 1));
      end
      send_request(r);
    end
  endtask

  // fill the stack past its depth, then unwind it
  task automatic overflow_stack();
    int id;
    for (int n = 0; n <= STACK_DEPTH; n++) begin
      id = $urandom_range(8, NUM_REGIONS - 1);
      send_request(make_request(nrta_pkg::REQ_PUSH, id, 0, 1'b0));
      if (!solo_open[id] && open_regions.size() < STACK_DEPTH)
        open_regions.push_back(id);
    end
    while (open_regions.size() > 0)
      send_request(make_request(nrta_pkg::REQ_POP, open_regions.pop_back(), 0, 1'b0));
  endtask

  // directed corner requests
  task automatic send_directed();
    nrta_pkg::in_req_t r;
    r = make_request(nrta_pkg::REQ_POP, 5, 0, 1'b0);
    send_request(r);
    r = make_request(nrta_pkg::REQ_PUSH, 63, 63, 1'b1);
    r.now_wall = '0;
    r.now_mem = '0;
    send_request(r);
    r = make_request(nrta_pkg::REQ_PUSH, 0, 0, 1'b0);
    r.now_wall = '1;
    r.now_mem = '1;
    send_request(r);
    send_request(make_request(nrta_pkg::REQ_POP, 63, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_POP, 0, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_POP, 63, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_START, 9, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_START, 9, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_PUSH, 9, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_STOP, 9, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_STOP, 9, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_COND_START, 12, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_COND_START, 12, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_COND_STOP, 12, 0, 1'b1));
    send_request(make_request(nrta_pkg::REQ_COND_STOP, 12, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_COND_STOP, 12, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_READ_REG, 63, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_READ_REG, 0, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_READ_REG, 12, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_READ_REG, 40, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_READ_PAIR, 63, 63, 1'b0));
    send_request(make_request(nrta_pkg::REQ_READ_PAIR, 0, 63, 1'b0));
    send_request(make_request(nrta_pkg::REQ_READ_PAIR, 0, 0, 1'b0));
  endtask

  // stimulus and verdict
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_detail(1'b0);
    send_directed();
    drain();
    write_detail(1'b1);
    // nested push, push, pop under detail charges a pair, read back before the last pop
    send_request(make_request(nrta_pkg::REQ_PUSH, 3, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_PUSH, 4, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_POP, 4, 0, 1'b0));
    send_request(make_request(nrta_pkg::REQ_READ_PAIR, 3, 4, 1'b0));
    send_request(make_request(nrta_pkg::REQ_POP, 3, 0, 1'b0));
    overflow_stack();
    send_random(400, 30);
    drain();
    write_detail(1'b0);
    send_random(350, 30);
    overflow_stack();
    drain();
    write_detail(1'b1);
    send_random(150, 55);
    send_random(300, 30);
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
